// ===== rtl/core/rhcs_pkg.sv =====
`timescale 1ns / 1ps
// Types, codes and hash arithmetic for the rolling hash chunk splitter.
// No dependencies; used by rolling_hash_chunk_splitter_top.
package rhcs_pkg;

  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 12;
  localparam int LEN_W       = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 17;
  localparam int WINDOW_LEN  = 16;
  localparam int MAX_BLOCK_DEF = 65536;

  localparam logic [LEN_W-1:0]  MIN_LEN_RESET = 17'd2048;
  localparam logic [HASH_W-1:0] RESIDUE_RESET = 12'd3453;

  localparam logic [HASH_W:0]   HASH_MOD  = 13'd4093;
  localparam logic [HASH_W-1:0] HASH_DROP = 12'd2998;
  localparam logic [HASH_W:0]   HASH_FOLD = 13'd4096 - HASH_MOD;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESIDUE = 1'd1;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_HASH = 2'd1,
    CAUSE_MAX  = 2'd2,
    CAUSE_EOF  = 2'd3
  } cause_t;

  function automatic logic [HASH_W-1:0] hash_next(
    input logic [HASH_W-1:0] h,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] lv
  );
    logic [20:0]     sum;
    logic [HASH_W:0] f1;
    logic [HASH_W:0] f2;
    sum = 21'({h, 8'h00}) + 21'(b) + 21'(lv) * 21'(HASH_DROP);
    f1  = 13'(sum[11:0]) + 13'(sum[20:12]) * HASH_FOLD;
    f2  = 13'(f1[11:0]) + (f1[12] ? HASH_FOLD : 13'd0);
    if (f2 >= HASH_MOD) begin
      f2 = f2 - HASH_MOD;
    end
    return f2[HASH_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rolling_hash_chunk_splitter_top.sv =====
`timescale 1ns / 1ps
// Content-defined chunk splitter: rolling hash mod 4093 over a 16-byte window.
// Depends on rhcs_pkg for codes, widths and the hash update function.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | data_byte, last_of_file
//   out_       | out | out_valid/out_ready| block_end, block_length, end_cause
//   cfg_       | in  | cfg_valid/cfg_ready| index, data (always ready)
//
// One item per cycle while in_ready is high; the result is registered and appears in the cycle after the item is taken.
// The hash update, window shift and count are computed combinationally and registered with the result.
// in_ready drops only while a result waits and out_ready is low.
// Reset (synchronous, rst_n low) clears window, hash, count and loads register defaults.
module rolling_hash_chunk_splitter_top
  import rhcs_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  in_last_of_file,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_block_end,
  output logic [LEN_W-1:0]      out_block_length,
  output logic [1:0]            out_end_cause,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  logic [LEN_W-1:0]  min_len_r;
  logic [HASH_W-1:0] residue_r;

  logic [BYTE_W-1:0] win_r   [WINDOW_LEN];
  logic [BYTE_W-1:0] win_nxt [WINDOW_LEN];
  logic [HASH_W-1:0] hash_r, hash_nxt, hash_upd;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [31:0]       cnt_ext;

  logic              out_valid_r;
  logic              out_block_end_r;
  logic [LEN_W-1:0]  out_len_r;
  cause_t            out_cause_r;
  cause_t            cause;

  logic              in_acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign hash_upd = hash_next(hash_r, in_data_byte, win_r[0]);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_ext  = 32'(cnt_inc);

  always_comb begin
    if (cnt_ext >= 32'(min_len_r) && hash_upd == residue_r) begin
      cause = CAUSE_HASH;
    end else if (cnt_ext >= 32'(MAX_BLOCK)) begin
      cause = CAUSE_MAX;
    end else if (in_last_of_file) begin
      cause = CAUSE_EOF;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  always_comb begin
    if (cause != CAUSE_NONE) begin
      hash_nxt = '0;
      cnt_nxt  = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_nxt[i] = '0;
      end
    end else begin
      hash_nxt = hash_upd;
      cnt_nxt  = cnt_inc;
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WINDOW_LEN-1] = in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
      residue_r <= RESIDUE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_LEN: min_len_r <= cfg_data;
        CFG_RESIDUE: residue_r <= cfg_data[HASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      cnt_r  <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else if (in_acc) begin
      hash_r <= hash_nxt;
      cnt_r  <= cnt_nxt;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_block_end_r <= (cause != CAUSE_NONE);
      out_len_r       <= cnt_ext[LEN_W-1:0];
      out_cause_r     <= cause;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_end    = out_block_end_r;
  assign out_block_length = out_len_r;
  assign out_end_cause    = out_cause_r;

`ifndef SYNTHESIS
  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    hash_r < HASH_MOD[HASH_W-1:0])
    else $error("hash out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < 32'(MAX_BLOCK))
    else $error("block count reached maximum without clearing");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cause != CAUSE_NONE) |=> (cnt_r == '0 && hash_r == '0))
    else $error("block end did not clear state");

  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_block_end_r == (out_cause_r != CAUSE_NONE)))
    else $error("block_end disagrees with end_cause");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cnt_inc == '0) |-> 1'b0)
    else $error("count wrapped");
`endif

endmodule

// ===== test/tb_rolling_hash_chunk_splitter_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rolling_hash_chunk_splitter_top: drives bytes, registers
// and output stalls, and checks every result against a scoreboard with its own hash model.
// Depends on rhcs_pkg and rolling_hash_chunk_splitter_top.
module tb_rolling_hash_chunk_splitter_top;
  import rhcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50_000;
  localparam int unsigned ROLL_BASE   = 256;
  localparam int unsigned MAX_LEN     = MAX_BLOCK_DEF;

  typedef struct {
    logic             block_end;
    logic [LEN_W-1:0] block_length;
    cause_t           end_cause;
  } chunk_result_t;

  class chunk_scoreboard;
    bit [BYTE_W-1:0]  window [WINDOW_LEN];
    int unsigned      hash;
    int unsigned      count;
    bit [LEN_W-1:0]   min_len;
    bit [HASH_W-1:0]  residue;
    chunk_result_t    expected_q[$];
    int unsigned      mismatches;
    int unsigned      items_seen;
    int unsigned      results_seen;
    int unsigned      hash_ends;
    int unsigned      max_ends;
    int unsigned      eof_ends;

    function new();
      min_len = MIN_LEN_RESET;
      residue = RESIDUE_RESET;
      clear_block();
    endfunction

    function void clear_block();
      foreach (window[i]) window[i] = '0;
      hash  = 0;
      count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MIN_LEN) begin
        min_len = data[LEN_W-1:0];
      end else begin
        residue = data[HASH_W-1:0];
      end
    endfunction

    function int unsigned roll(int unsigned h, int unsigned b, int unsigned lv);
      return (h * ROLL_BASE + b + lv * HASH_DROP) % HASH_MOD;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Pick two bytes that bring the hash to target after the second one.
    function bit steer_pair(input int unsigned target, output bit [7:0] first,
                            output bit [7:0] second);
      int unsigned h1;
      int unsigned t;
      int unsigned need;
      int unsigned c0;
      int unsigned c;
      first  = '0;
      second = '0;
      c0 = $urandom_range(255);
      for (int k = 0; k < 256; k++) begin
        c    = (c0 + k) % 256;
        h1   = roll(hash, c, window[0]);
        t    = (h1 * ROLL_BASE + window[1] * HASH_DROP) % HASH_MOD;
        need = (target + HASH_MOD - t) % HASH_MOD;
        if (need < 256) begin
          first  = c[7:0];
          second = need[7:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_input(bit [BYTE_W-1:0] b, bit last);
      chunk_result_t r;
      cause_t        cause;
      hash = roll(hash, b, window[0]);
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] = window[i+1];
      window[WINDOW_LEN-1] = b;
      count++;
      if (count >= min_len && hash == residue) begin
        cause = CAUSE_HASH;
        hash_ends++;
      end else if (count >= MAX_LEN) begin
        cause = CAUSE_MAX;
        max_ends++;
      end else if (last) begin
        cause = CAUSE_EOF;
        eof_ends++;
      end else begin
        cause = CAUSE_NONE;
      end
      r.block_end    = (cause != CAUSE_NONE);
      r.block_length = count[LEN_W-1:0];
      r.end_cause    = cause;
      expected_q.push_back(r);
      items_seen++;
      if (cause != CAUSE_NONE) clear_block();
    endfunction

    function void check_result(logic be, logic [LEN_W-1:0] len, logic [1:0] cause);
      chunk_result_t r;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result end=%0b len=%0d cause=%0d", be, len, cause);
        return;
      end
      r = expected_q.pop_front();
      if (be !== r.block_end || len !== r.block_length || cause !== r.end_cause) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at result %0d: expected end=%0b len=%0d cause=%0d, ",
                    "got end=%0b len=%0d cause=%0d"},
                   results_seen, r.block_end, r.block_length, r.end_cause, be, len, cause);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  in_last_of_file;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_block_end;
  logic [LEN_W-1:0]      out_block_length;
  logic [1:0]            out_end_cause;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  chunk_scoreboard sb;
  bit              no_gaps;
  int unsigned     cycle_count;

  rolling_hash_chunk_splitter_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_of_file  (in_last_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_block_end    (out_block_end),
    .out_block_length (out_block_length),
    .out_end_cause    (out_end_cause),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("** rolling_hash_chunk_splitter_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_block_end, out_block_length, out_end_cause);
    out_ready <= no_gaps || ($urandom_range(99) >= 29);
  end

  task automatic send_item(input bit [BYTE_W-1:0] b, input bit last);
    if (!no_gaps) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_last_of_file <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, last);
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned min_len, input int unsigned res);
    drain();
    write_reg(CFG_MIN_LEN, min_len[CFG_DATA_W-1:0]);
    write_reg(CFG_RESIDUE, {5'($urandom), res[HASH_W-1:0]});
  endtask

  task automatic send_boundary_pair(input bit last);
    bit [7:0] b1;
    bit [7:0] b0;
    if (sb.steer_pair(sb.residue, b1, b0)) begin
      send_item(b1, 1'b0);
      send_item(b0, last);
    end else begin
      send_item(8'($urandom), 1'b0);
      send_item(8'($urandom), last);
    end
  endtask

  task automatic run_files(input int n_items);
    int sent;
    int file_left;
    sent      = 0;
    file_left = ($urandom_range(99) < 85) ? $urandom_range(1, 40) : $urandom_range(41, 300);
    while (sent < n_items) begin
      if (sb.residue < HASH_MOD && file_left >= 2 && sb.count + 2 >= sb.min_len &&
          $urandom_range(99) < 12) begin
        send_boundary_pair(file_left == 2);
        sent      += 2;
        file_left -= 2;
      end else begin
        send_item(8'($urandom), file_left == 1);
        sent      += 1;
        file_left -= 1;
      end
      if (file_left == 0)
        file_left = ($urandom_range(99) < 85) ? $urandom_range(1, 40) : $urandom_range(41, 300);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_last_of_file = 1'b0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    no_gaps         = 1'b0;
    cycle_count     = 0;
    sb              = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, single-byte file
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h7F, 1'b1);
    send_item(8'hA5, 1'b1);

    // zero minimum: first byte may end a block; hash beats end of file
    set_regs(0, 'h5A);
    send_item(8'h5A, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b0);

    // short block as long as the window, top residue
    set_regs(16, 4092);
    repeat (14) send_item(8'($urandom), 1'b0);
    send_boundary_pair(1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_regs(0, $urandom_range(255));
        1: set_regs(1, $urandom_range(4092));
        2: set_regs(16, 0);
        3: set_regs($urandom_range(2, 40), 4092);
        4: set_regs($urandom_range(17, 64), $urandom_range(4093, 4095));
        5: set_regs(17'h1FFFF, $urandom_range(4092));
        6: set_regs($urandom_range(15), $urandom_range(4092));
        default: set_regs($urandom_range(100), $urandom_range(4092));
      endcase
      no_gaps = (p == 2 || p == 3);
      run_files(65);
    end
    no_gaps = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes over %0d results: %0d hash ends, %0d max-length ends, %0d %s",
             sb.items_seen, sb.results_seen, sb.hash_ends, sb.max_ends, sb.eof_ends,
             "file ends");
    $display("minimum lengths 0 to 131071 and residues 0 to 4095 were set; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** rolling_hash_chunk_splitter_top: PASSED **");
    end else begin
      $display("** rolling_hash_chunk_splitter_top: FAILED **");
    end
    $finish;
  end

endmodule
